@@ src/bsgs_pkg.sv @@
// Shared types, widths and codes for the Black-Scholes grid stencil unit.
// No dependencies; imported by the controller, the datapath, the top level and the testbench.
`timescale 1ns / 1ps

package bsgs_pkg;

    // Fixed-point word: signed, VALUE_WIDTH bits, FRAC_BITS fraction bits by default.
    localparam int VALUE_WIDTH = 48;
    localparam int FRAC_BITS   = 24;

    // Multiplier chunking: the multiplier operand is consumed CHUNK bits a cycle.
    localparam int CHUNK     = 16;
    localparam int NCHUNK    = (VALUE_WIDTH + CHUNK - 1) / CHUNK;
    localparam int MAG_A_W   = VALUE_WIDTH + 2;
    localparam int MAG_B_W   = NCHUNK * CHUNK;
    localparam int PROD_W    = MAG_A_W + MAG_B_W;
    localparam int CNT_W     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SIGMA_SQ  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_DIFF      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISKFREE_RATE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_SQ    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUNDARY = 3'd5;

    // Multiplication codes, in the order the controller issues them.
    typedef logic [2:0] t_op;
    localparam t_op OP_DELTA = 3'd0;  // (right - left) * inv_step / 2
    localparam t_op OP_GAMMA = 3'd1;  // (right - 2 centre + left) * inv_step_sq
    localparam t_op OP_P1    = 3'd2;  // half_sigma_sq * spot
    localparam t_op OP_P2    = 3'd3;  // p1 * spot
    localparam t_op OP_T1    = 3'd4;  // p2 * gamma
    localparam t_op OP_Q1    = 3'd5;  // rate_diff * spot
    localparam t_op OP_T2    = 3'd6;  // q1 * delta
    localparam t_op OP_T3    = 3'd7;  // riskfree_rate * centre

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] grid_value;
        logic [VALUE_WIDTH-2:0]        spot_price;
        logic                          active_flag;
        logic                          last_point;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] point_value;
        logic signed [VALUE_WIDTH-1:0] delta_out;
        logic signed [VALUE_WIDTH-1:0] gamma_out;
        logic signed [VALUE_WIDTH-1:0] operator_value;
        logic signed [VALUE_WIDTH-1:0] rate_out;
        logic                          last_out;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic load_a;
        logic load_b;
        logic start;
        t_op  op;
        logic sum;
        logic push;
        logic update;
    } t_ctl_cmd;

    typedef struct packed {
        logic fill;
        logic in_last;
        logic mul_done;
        logic out_free;
    } t_ctl_status;

    // Clamp a value two bits wider than a word to the signed word range.
    function automatic logic signed [VALUE_WIDTH-1:0] sat_word(
        input logic signed [VALUE_WIDTH+1:0] x
    );
        logic signed [VALUE_WIDTH+1:0] maxv;
        logic signed [VALUE_WIDTH+1:0] minv;
        maxv = (VALUE_WIDTH+2)'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
        minv = ~maxv;
        if (x > maxv) begin
            sat_word = maxv[VALUE_WIDTH-1:0];
        end else if (x < minv) begin
            sat_word = minv[VALUE_WIDTH-1:0];
        end else begin
            sat_word = x[VALUE_WIDTH-1:0];
        end
    endfunction

endpackage

@@ src/black_scholes_grid_stencil_unit.sv @@
// One transaction at a time: the input stalls until the point's results are pushed and
// the window is updated. A point gives one result, a last point two (its predecessor's and
// its own; one for a one-point sweep) and the first point of a sweep none. The shared
// multiplier does each result's eight products in turn; an output stall can hold the block.
// Reset: synchronous, active low; clears window, controller and output valid, sets the step
// registers to 1.0 and the other configuration registers to 0.
`timescale 1ns / 1ps

module black_scholes_grid_stencil_unit
    import bsgs_pkg::*;
#(
    parameter int FRAC_BITS_P = FRAC_BITS
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input channel: one grid point per transaction.
    input  logic                   i_in_valid,
    input  t_in_item               i_in_data,
    output logic                   o_in_stall,
    // Output channel: one stencil result per transaction.
    output logic                   o_out_valid,
    output t_out_item              o_out_data,
    input  logic                   i_out_stall,
    // Configuration write port.
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [VALUE_WIDTH-1:0] i_cfg_data
);

    // The controller walks each point through its window loads and the fixed
    // list of multiplications; the datapath holds every data register and does the math.
    t_ctl_cmd    cmd;
    t_ctl_status status;

    bsgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath's output register lets a finished result wait for the
    // consumer while the next grid point is already being worked on.
    bsgs_dp #(
        .FRAC_BITS_P (FRAC_BITS_P)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

`ifndef ASSERT_OFF
    // A result is only pushed when the output register can take it.
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> status.out_free)
        else $error("result pushed into an occupied output register");

    // After taking a transaction the block is busy with it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again before the previous point finished");

    // A multiplication never finishes in the cycle right after it starts.
    a_mul_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |=> !status.mul_done)
        else $error("multiplier reported done too early");
`endif

endmodule

@@ src/bsgs_ctrl.sv @@
// Controller of the grid stencil unit: sequences input capture, window loads, the eight
// multiplications of each result, the final sum, the output push and the window update. Uses bsgs_pkg.
`timescale 1ns / 1ps

module bsgs_ctrl
    import bsgs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_ctl_status i_status,
    output t_ctl_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SEL_A = 3'd1;
    localparam logic [2:0] S_SEL_B = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;
    localparam logic [2:0] S_PUSH  = 3'd6;
    localparam logic [2:0] S_UPD   = 3'd7;

    logic [2:0] r_state, n_state;
    t_op        r_op, n_op;
    logic       r_is_a, n_is_a;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_is_a  = r_is_a;
        o_cmd   = '0;
        o_cmd.op = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_SEL_A;
                end
            end
            S_SEL_A: begin
                if (i_status.fill) begin
                    o_cmd.load_a = 1'b1;
                    n_is_a  = 1'b1;
                    n_op    = OP_DELTA;
                    n_state = S_MUL;
                end else begin
                    n_state = S_SEL_B;
                end
            end
            S_SEL_B: begin
                if (i_status.in_last) begin
                    o_cmd.load_b = 1'b1;
                    n_is_a  = 1'b0;
                    n_op    = OP_DELTA;
                    n_state = S_MUL;
                end else begin
                    n_state = S_UPD;
                end
            end
            S_MUL: begin
                o_cmd.start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_status.mul_done) begin
                    if (r_op == OP_T3) begin
                        n_state = S_SUM;
                    end else begin
                        n_op    = r_op + 3'd1;
                        n_state = S_MUL;
                    end
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = r_is_a ? S_SEL_B : S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_DELTA;
            r_is_a  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_is_a  <= n_is_a;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ src/bsgs_dp.sv @@
// Datapath of the grid stencil unit: configuration registers, the three-point
// window, a chunked multiplier with rounding, the operator sum and the output register.
`timescale 1ns / 1ps

module bsgs_dp
    import bsgs_pkg::*;
#(
    parameter int FRAC_BITS_P = FRAC_BITS
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ctl_cmd               i_cmd,
    output t_ctl_status            o_status,
    input  t_in_item               i_in_data,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [VALUE_WIDTH-1:0] i_cfg_data,
    output logic                   o_out_valid,
    output t_out_item              o_out_data,
    input  logic                   i_out_stall
);

    localparam int W = VALUE_WIDTH;
    localparam logic [PROD_W:0] HALF_F  = (PROD_W+1)'(1) << (FRAC_BITS_P - 1);
    localparam logic [PROD_W:0] HALF_F1 = (PROD_W+1)'(1) << FRAC_BITS_P;
    localparam logic [PROD_W:0] MAXV    = (PROD_W+1)'({1'b0, {(W-1){1'b1}}});

    // Configuration.
    logic [W-2:0]        r_half_sigma_sq, r_inv_step, r_inv_step_sq;
    logic signed [W-1:0] r_rate_diff, r_riskfree_rate, r_upper_boundary;

    // Captured input and window.
    logic signed [W-1:0] r_in_value;
    logic [W-2:0]        r_in_spot;
    logic                r_in_act, r_in_last;
    logic signed [W-1:0] r_older, r_middle;
    logic [W-2:0]        r_mid_spot;
    logic                r_mid_act, r_fill;

    // Operands of the result being computed.
    logic signed [W-1:0] r_left, r_centre, r_right;
    logic [W-2:0]        r_spot;
    logic                r_act, r_last;

    // Intermediate products.
    logic signed [W-1:0] r_delta, r_gamma, r_p1, r_p2, r_t1, r_q1, r_t2, r_t3, r_l;

    // Multiplier.
    logic [MAG_A_W-1:0]  r_a;
    logic [MAG_B_W-1:0]  r_b;
    logic [PROD_W-1:0]   r_acc;
    logic                r_neg, r_busy, r_rnd;
    logic [CNT_W-1:0]    r_cnt;
    t_op                 r_mop;

    logic                r_out_valid;
    t_out_item           r_out_data;

    // Operand selection at start.
    logic signed [W+1:0] sa;
    logic signed [W:0]   sb;
    logic [MAG_A_W-1:0]  a_mag;
    logic [W:0]          b_abs;

    always_comb begin
        sa = '0;
        sb = '0;
        unique case (i_cmd.op)
            OP_DELTA: begin
                sa = (W+2)'(r_right) - (W+2)'(r_left);
                sb = (W+1)'({1'b0, r_inv_step});
            end
            OP_GAMMA: begin
                sa = (W+2)'(r_right) + (W+2)'(r_left) - ((W+2)'(r_centre) <<< 1);
                sb = (W+1)'({1'b0, r_inv_step_sq});
            end
            OP_P1: begin
                sa = (W+2)'({1'b0, r_half_sigma_sq});
                sb = (W+1)'({1'b0, r_spot});
            end
            OP_P2: begin
                sa = (W+2)'(r_p1);
                sb = (W+1)'({1'b0, r_spot});
            end
            OP_T1: begin
                sa = (W+2)'(r_p2);
                sb = (W+1)'(r_gamma);
            end
            OP_Q1: begin
                sa = (W+2)'(r_rate_diff);
                sb = (W+1)'({1'b0, r_spot});
            end
            OP_T2: begin
                sa = (W+2)'(r_q1);
                sb = (W+1)'(r_delta);
            end
            OP_T3: begin
                sa = (W+2)'(r_riskfree_rate);
                sb = (W+1)'(r_centre);
            end
            default: begin
                sa = '0;
                sb = '0;
            end
        endcase
        a_mag = sa[W+1] ? MAG_A_W'(-sa) : MAG_A_W'(sa);
        b_abs = sb[W] ? (~sb + (W+1)'(1)) : sb;
    end

    // One chunk a cycle, most significant chunk first.
    logic [MAG_A_W+CHUNK-1:0] part;
    assign part = {{CHUNK{1'b0}}, r_a} * {{MAG_A_W{1'b0}}, r_b[MAG_B_W-1 -: CHUNK]};

    // Rounding (nearest, ties away from zero) and saturation of the magnitude.
    logic [PROD_W:0] rnd_sum, q, lim;
    logic [W-1:0]    mag_w, res;

    always_comb begin
        rnd_sum = {1'b0, r_acc} + ((r_mop == OP_DELTA) ? HALF_F1 : HALF_F);
        q       = (r_mop == OP_DELTA) ? (rnd_sum >> (FRAC_BITS_P + 1))
                                      : (rnd_sum >> FRAC_BITS_P);
        lim     = r_neg ? (MAXV + (PROD_W+1)'(1)) : MAXV;
        mag_w   = (q > lim) ? lim[W-1:0] : q[W-1:0];
        res     = r_neg ? (~mag_w + W'(1)) : mag_w;
    end

    // Operator sum with saturation after each addition.
    logic signed [W-1:0] s1, l_val;
    assign s1    = sat_word((W+2)'(r_t1) + (W+2)'(r_t2));
    assign l_val = sat_word((W+2)'(s1) - (W+2)'(r_t3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_sigma_sq  <= '0;
            r_rate_diff      <= '0;
            r_riskfree_rate  <= '0;
            r_inv_step       <= (W-1)'(1) << FRAC_BITS_P;
            r_inv_step_sq    <= (W-1)'(1) << FRAC_BITS_P;
            r_upper_boundary <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HALF_SIGMA_SQ:  r_half_sigma_sq  <= i_cfg_data[W-2:0];
                CFG_RATE_DIFF:      r_rate_diff      <= i_cfg_data;
                CFG_RISKFREE_RATE:  r_riskfree_rate  <= i_cfg_data;
                CFG_INV_STEP:       r_inv_step       <= i_cfg_data[W-2:0];
                CFG_INV_STEP_SQ:    r_inv_step_sq    <= i_cfg_data[W-2:0];
                CFG_UPPER_BOUNDARY: r_upper_boundary <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Window state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older    <= '0;
            r_middle   <= '0;
            r_mid_spot <= '0;
            r_mid_act  <= 1'b0;
            r_fill     <= 1'b0;
        end else if (i_cmd.load_a) begin
            r_older <= r_middle;
        end else if (i_cmd.update) begin
            if (r_in_last) begin
                r_older    <= '0;
                r_middle   <= '0;
                r_mid_spot <= '0;
                r_mid_act  <= 1'b0;
                r_fill     <= 1'b0;
            end else begin
                r_middle   <= r_in_value;
                r_mid_spot <= r_in_spot;
                r_mid_act  <= r_in_act;
                r_fill     <= 1'b1;
            end
        end
    end

    // Captured input and result operands.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_value <= i_in_data.grid_value;
            r_in_spot  <= i_in_data.spot_price;
            r_in_act   <= i_in_data.active_flag;
            r_in_last  <= i_in_data.last_point;
        end
        if (i_cmd.load_a) begin
            r_left   <= r_older;
            r_centre <= r_middle;
            r_right  <= r_in_value;
            r_spot   <= r_mid_spot;
            r_act    <= r_mid_act;
            r_last   <= 1'b0;
        end else if (i_cmd.load_b) begin
            r_left   <= r_older;
            r_centre <= r_in_value;
            r_right  <= r_upper_boundary;
            r_spot   <= r_in_spot;
            r_act    <= r_in_act;
            r_last   <= 1'b1;
        end
        if (i_cmd.sum) begin
            r_l <= l_val;
        end
    end

    // Multiplier control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rnd  <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_rnd  <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(NCHUNK - 1)) begin
                r_busy <= 1'b0;
                r_rnd  <= 1'b1;
            end
        end else begin
            r_rnd <= 1'b0;
        end
    end

    // Multiplier data and product destinations.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_a   <= a_mag;
            r_b   <= MAG_B_W'(b_abs[W-1:0]);
            r_neg <= sa[W+1] ^ sb[W];
            r_acc <= '0;
            r_mop <= i_cmd.op;
        end else if (r_busy) begin
            r_acc <= (r_acc << CHUNK) + PROD_W'(part);
            r_b   <= r_b << CHUNK;
        end
        if (r_rnd) begin
            unique case (r_mop)
                OP_DELTA: r_delta <= res;
                OP_GAMMA: r_gamma <= res;
                OP_P1:    r_p1    <= res;
                OP_P2:    r_p2    <= res;
                OP_T1:    r_t1    <= res;
                OP_Q1:    r_q1    <= res;
                OP_T2:    r_t2    <= res;
                OP_T3:    r_t3    <= res;
                default:  r_t3    <= res;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_data.point_value    <= r_centre;
            r_out_data.delta_out      <= r_delta;
            r_out_data.gamma_out      <= r_gamma;
            r_out_data.operator_value <= r_l;
            r_out_data.rate_out       <= r_act ? r_l : '0;
            r_out_data.last_out       <= r_last;
        end
    end

    assign o_status.fill     = r_fill;
    assign o_status.in_last  = r_in_last;
    assign o_status.mul_done = r_rnd;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the Black-Scholes grid stencil unit.
// Depends on bsgs_pkg and black_scholes_grid_stencil_unit from the RTL sources.
// Drives sweeps of grid points and checks each stencil result against an in-bench predictor.
`timescale 1ns / 1ps

module testbench;
    import bsgs_pkg::*;

    localparam int W           = VALUE_WIDTH;
    localparam int SETTLE      = 120;      // cycles after the last result before a config write
    localparam int CYCLE_LIMIT = 2000000;  // far above the slowest correct run
    localparam int LONG_HOLD   = 400;      // long receiver stall, in cycles
    // The index space has room beyond the six registers; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef logic signed [127:0] t_wide;
    typedef logic signed [W-1:0] t_word;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    t_in_item               i_in_data;
    logic                   o_in_stall;
    logic                   o_out_valid;
    t_out_item              o_out_data;
    logic                   i_out_stall;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [VALUE_WIDTH-1:0] i_cfg_data;

    black_scholes_grid_stencil_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Clock: 10 ns period.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predictor copy of the configuration registers.
    logic [W-2:0] half_sigma_sq_q;
    t_word        rate_diff_q;
    t_word        riskfree_q;
    logic [W-2:0] inv_step_q;
    logic [W-2:0] inv_step_sq_q;
    t_word        upper_bound_q;

    // Predictor copy of the three-point window.
    t_word        left_val;
    t_word        centre_val;
    logic [W-2:0] centre_spot;
    logic         centre_active;
    logic         centre_held;

    t_in_item  grid_points[$];        // points waiting to be offered
    t_out_item stencil_results[$];    // predicted results, oldest first

    int  mismatches = 0;
    int  cycle_count = 0;
    bit  in_fire = 0;                 // set at the edge that takes an input transaction
    bit  out_fire = 0;                // set at the edge that takes an output transaction
    bit  in_busy = 0;
    bit  no_idle = 0;                 // when set, neither side inserts gaps
    bit  long_hold_req = 0;
    int  in_gap = 0;
    int  out_gap = 0;
    int  hold_left = 0;
    t_in_item cur_point;

    // Round a product to the word by dropping sh fraction bits, nearest with ties
    // away from zero, then clamp to the signed word range.
    function automatic t_word round_sat(t_wide p, int sh);
        t_wide mag;
        t_wide lim;
        t_wide res;
        logic  neg;
        neg = p < 0;
        mag = neg ? -p : p;
        mag = (mag + (t_wide'(1) <<< (sh - 1))) >> sh;
        lim = (t_wide'(1) <<< (W - 1)) - 1 + neg;
        if (mag > lim) begin
            mag = lim;
        end
        res = neg ? -mag : mag;
        return res[W-1:0];
    endfunction

    function automatic t_word fx_mul(t_wide a, t_wide b);
        return round_sat(a * b, FRAC_BITS);
    endfunction

    function automatic t_word clamp_word(t_wide x);
        t_wide maxv;
        maxv = (t_wide'(1) <<< (W - 1)) - 1;
        if (x > maxv) begin
            return maxv[W-1:0];
        end else if (x < -maxv - 1) begin
            return t_word'(-maxv - 1);
        end
        return x[W-1:0];
    endfunction

    // One stencil result for centre v with neighbours left and right.
    function automatic t_out_item stencil(t_word left, t_word v, t_word right,
                                          logic [W-2:0] spot, logic act, logic last);
        t_out_item r;
        t_wide d1;
        t_wide d2;
        t_wide s;
        t_word delta;
        t_word gamma;
        t_word t1;
        t_word t2;
        t_word t3;
        t_word op;
        s  = t_wide'({1'b0, spot});
        d1 = t_wide'(right) - t_wide'(left);
        d2 = t_wide'(right) + t_wide'(left) - 2 * t_wide'(v);
        delta = round_sat(d1 * t_wide'({1'b0, inv_step_q}), FRAC_BITS + 1);
        gamma = round_sat(d2 * t_wide'({1'b0, inv_step_sq_q}), FRAC_BITS);
        t1 = fx_mul(fx_mul(fx_mul(t_wide'({1'b0, half_sigma_sq_q}), s), s), gamma);
        t2 = fx_mul(fx_mul(rate_diff_q, s), delta);
        t3 = fx_mul(riskfree_q, v);
        op = clamp_word(t_wide'(clamp_word(t_wide'(t1) + t_wide'(t2))) - t_wide'(t3));
        r.point_value    = v;
        r.delta_out      = delta;
        r.gamma_out      = gamma;
        r.operator_value = op;
        r.rate_out       = act ? op : '0;
        r.last_out       = last;
        return r;
    endfunction

    // Advance the predicted window by one accepted grid point.
    task automatic predict_point(t_in_item p);
        if (!centre_held) begin
            left_val = '0;
        end else begin
            stencil_results.push_back(stencil(left_val, centre_val, p.grid_value,
                                              centre_spot, centre_active, 1'b0));
            left_val = centre_val;
        end
        if (p.last_point) begin
            stencil_results.push_back(stencil(left_val, p.grid_value, upper_bound_q,
                                              p.spot_price, p.active_flag, 1'b1));
            left_val      = '0;
            centre_val    = '0;
            centre_spot   = '0;
            centre_active = 1'b0;
            centre_held   = 1'b0;
        end else begin
            centre_val    = p.grid_value;
            centre_spot   = p.spot_price;
            centre_active = p.active_flag;
            centre_held   = 1'b1;
        end
    endtask

    task automatic report(string field, logic [W-1:0] got, logic [W-1:0] want);
        $display("mismatch on %s: got %h, expected %h (cycle %0d)", field, got, want,
                 cycle_count);
        mismatches++;
    endtask

    // Monitor: samples at the rising edge, before the block updates its outputs.
    always @(posedge i_clk) begin
        t_out_item want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            if (i_rst_n && i_in_valid && !o_in_stall) begin
                predict_point(i_in_data);
                in_fire = 1;
            end
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                out_fire = 1;
                if (stencil_results.size() == 0) begin
                    report("unexpected transaction", o_out_data.point_value, '0);
                end else begin
                    want = stencil_results.pop_front();
                    if (o_out_data.point_value !== want.point_value)
                        report("point_value", o_out_data.point_value, want.point_value);
                    if (o_out_data.delta_out !== want.delta_out)
                        report("delta_out", o_out_data.delta_out, want.delta_out);
                    if (o_out_data.gamma_out !== want.gamma_out)
                        report("gamma_out", o_out_data.gamma_out, want.gamma_out);
                    if (o_out_data.operator_value !== want.operator_value)
                        report("operator_value", o_out_data.operator_value,
                               want.operator_value);
                    if (o_out_data.rate_out !== want.rate_out)
                        report("rate_out", o_out_data.rate_out, want.rate_out);
                    if (o_out_data.last_out !== want.last_out)
                        report("last_out", W'(o_out_data.last_out), W'(want.last_out));
                end
            end
        end
    end

    // Input driver: changes the channel at the falling edge. The valid level is
    // worked out first and assigned once, so a back-to-back transaction keeps it high.
    always @(negedge i_clk) begin
        if (in_fire) begin
            in_fire = 0;
            in_busy = 0;
            in_gap  = no_idle ? 0 : $urandom_range(0, 4);
        end
        if (i_rst_n && !in_busy && grid_points.size() > 0) begin
            if (in_gap > 0) begin
                in_gap--;
            end else begin
                cur_point = grid_points.pop_front();
                in_busy   = 1;
            end
        end
        i_in_valid <= in_busy;
        if (in_busy) begin
            i_in_data <= cur_point;
        end
    end

    // Output receiver: a random wait per result, plus one long hold on request.
    always @(negedge i_clk) begin
        if (out_fire) begin
            out_fire = 0;
            out_gap  = no_idle ? 0 : $urandom_range(0, 4);
        end
        if (long_hold_req) begin
            long_hold_req = 0;
            hold_left     = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic wait_idle();
        while (grid_points.size() != 0 || in_busy || stencil_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // One register write at the falling edge; the predictor follows it.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_HALF_SIGMA_SQ:  half_sigma_sq_q = val[W-2:0];
            CFG_RATE_DIFF:      rate_diff_q     = val;
            CFG_RISKFREE_RATE:  riskfree_q      = val;
            CFG_INV_STEP:       inv_step_q      = val[W-2:0];
            CFG_INV_STEP_SQ:    inv_step_sq_q   = val[W-2:0];
            CFG_UPPER_BOUNDARY: upper_bound_q   = val;
            default: ;
        endcase
    endtask

    task automatic cfg_all(logic [W-1:0] hss, logic [W-1:0] rd, logic [W-1:0] rf,
                           logic [W-1:0] inv, logic [W-1:0] inv_sq, logic [W-1:0] ub);
        cfg_write(CFG_HALF_SIGMA_SQ, hss);
        cfg_write(CFG_RATE_DIFF, rd);
        cfg_write(CFG_RISKFREE_RATE, rf);
        cfg_write(CFG_INV_STEP, inv);
        cfg_write(CFG_INV_STEP_SQ, inv_sq);
        cfg_write(CFG_UPPER_BOUNDARY, ub);
    endtask

    function automatic logic [W-1:0] rand_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0, 1: return r[W-1:0];
            2:    return W'($signed(r[31:0]));              // up to about +-128
            3:    return W'($signed(r[37:0]));              // mid range
            4:    return W'($signed(r[27:0]));              // near zero
            default: begin
                case ($urandom_range(0, 2))
                    0: return {1'b0, {(W-1){1'b1}}};
                    1: return {1'b1, {(W-1){1'b0}}};
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    function automatic logic [W-2:0] rand_spot();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0:    return r[W-2:0];
            1:    return ($urandom_range(0, 1) == 1) ? {(W-1){1'b1}} : '0;
            default: return (W-1)'(($urandom_range(0, 250) << FRAC_BITS) + r[23:0]);
        endcase
    endfunction

    task automatic add_point(logic [W-1:0] v, logic [W-2:0] s, logic act, logic last);
        t_in_item p;
        p.grid_value  = v;
        p.spot_price  = s;
        p.active_flag = act;
        p.last_point  = last;
        grid_points.push_back(p);
    endtask

    // Random sweeps: mostly well-formed, some single points, a few left open so
    // that the next sweep continues the window.
    task automatic add_sweeps(int count);
        int n;
        int len;
        bit open_end;
        n = 0;
        while (n < count) begin
            len      = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
            open_end = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < len; k++) begin
                add_point(rand_word(), rand_spot(), $urandom_range(0, 3) != 0,
                          (k == len - 1) && !open_end);
            end
            n += len;
        end
    endtask

    function automatic logic [W-1:0] rand_cfg();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return ($urandom_range(0, 1) == 1) ? r[W-1:0] : W'($signed(r[27:0]));
    endfunction

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        half_sigma_sq_q = '0;
        rate_diff_q     = '0;
        riskfree_q      = '0;
        inv_step_q      = (W-1)'(1) << FRAC_BITS;
        inv_step_sq_q   = (W-1)'(1) << FRAC_BITS;
        upper_bound_q   = '0;
        left_val      = '0;
        centre_val    = '0;
        centre_spot   = '0;
        centre_active = 1'b0;
        centre_held   = 1'b0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset configuration: a single-point sweep, a frozen point, field extremes.
        add_point(48'sd5 << FRAC_BITS, 47'd100 << FRAC_BITS, 1'b1, 1'b1);
        add_point({1'b0, {(W-1){1'b1}}}, {(W-1){1'b1}}, 1'b1, 1'b0);
        add_point({1'b1, {(W-1){1'b0}}}, '0, 1'b0, 1'b0);
        add_point({1'b0, {(W-1){1'b1}}}, {(W-1){1'b1}}, 1'b1, 1'b1);
        add_point('0, '0, 1'b0, 1'b1);
        wait_idle();

        // A realistic market: sigma 20 percent, r 5 percent, q 2 percent, step 0.5.
        cfg_all(48'd335544, 48'd503316, 48'd838861, 48'd2 << FRAC_BITS,
                48'd4 << FRAC_BITS, 48'd100 << FRAC_BITS);
        cfg_write(CFG_SPARE_A, '1);
        cfg_write(CFG_SPARE_B, rand_cfg());
        for (int k = 0; k < 6; k++)
            add_point(W'(k) << FRAC_BITS, (W-1)'(k) << (FRAC_BITS - 1), k != 3, k == 5);
        // The receiver holds off while points keep coming, so the block backs up.
        no_idle = 1;
        long_hold_req = 1;
        add_sweeps(60);
        wait_idle();
        no_idle = 0;
        add_sweeps(300);
        wait_idle();

        // Positive extremes with a negative risk-free rate.
        cfg_all({1'b0, {(W-1){1'b1}}}, {1'b0, {(W-1){1'b1}}}, {1'b1, {(W-1){1'b0}}},
                {1'b0, {(W-1){1'b1}}}, {1'b0, {(W-1){1'b1}}}, {1'b0, {(W-1){1'b1}}});
        add_point({1'b1, {(W-1){1'b0}}}, {(W-1){1'b1}}, 1'b1, 1'b0);
        add_point({1'b0, {(W-1){1'b1}}}, {(W-1){1'b1}}, 1'b1, 1'b0);
        add_point({1'b1, {(W-1){1'b0}}}, {(W-1){1'b1}}, 1'b0, 1'b1);
        add_sweeps(200);
        wait_idle();

        // All zero with the most negative boundary; half_sigma_sq and inv_step get a one only above their width.
        cfg_all({1'b1, {(W-1){1'b0}}}, '0, '0, {1'b1, {(W-1){1'b0}}}, '0,
                {1'b1, {(W-1){1'b0}}});
        add_sweeps(150);
        wait_idle();

        // Random settings.
        for (int ph = 0; ph < 4; ph++) begin
            cfg_all(rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg());
            no_idle = (ph == 2);
            add_sweeps(250);
            wait_idle();
        end
        no_idle = 0;

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ black_scholes_grid_stencil_unit.f @@
src/bsgs_pkg.sv
src/bsgs_ctrl.sv
src/bsgs_dp.sv
src/black_scholes_grid_stencil_unit.sv
tb/testbench.sv
